// File: hdl/fasta_stream_tokenizer_macros.svh
// ----------------------------------------------------------------------------
// FASTA stream tokenizer assertion macros
// Shared concurrent assertion forms used by the tokenizer modules.
// ----------------------------------------------------------------------------
`ifndef FASTA_STREAM_TOKENIZER_MACROS_SVH
`define FASTA_STREAM_TOKENIZER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define FST_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tokenizer assertion failed");

// Next-cycle implication, checked outside reset.
`define FST_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tokenizer assertion failed");

`endif

// File: hdl/fst_pkg.sv
// ----------------------------------------------------------------------------
// FASTA stream tokenizer package
// Token codes, character constants, the token type and the letter check.
// ----------------------------------------------------------------------------
package fst_pkg;

	localparam int RecordIndexBitsDefault = 16;
	localparam int IndexOutBits = 16;

	localparam logic [2:0] KIND_NAME_CHAR = 3'd0;
	localparam logic [2:0] KIND_NAME_END  = 3'd1;
	localparam logic [2:0] KIND_SEQ_CHAR  = 3'd2;
	localparam logic [2:0] KIND_REC_END   = 3'd3;
	localparam logic [2:0] KIND_ERROR     = 3'd4;

	localparam logic ERR_BAD_CHAR = 1'b0;
	localparam logic ERR_BAD_MOD  = 1'b1;

	localparam logic [7:0] CH_GT      = 8'h3E;
	localparam logic [7:0] CH_BAR     = 8'h7C;
	localparam logic [7:0] CH_LPAREN  = 8'h28;
	localparam logic [7:0] CH_I       = 8'h69;
	localparam logic [7:0] CH_RPAREN  = 8'h29;
	localparam logic [7:0] CH_DASH    = 8'h2D;
	localparam logic [7:0] CH_N       = 8'h4E;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_NEWLINE = 8'h0A;

	typedef struct packed {
		logic                    valid;
		logic [2:0]              kind;
		logic [7:0]              char_val;
		logic [IndexOutBits-1:0] index;
		logic                    err;
	} token_t;

	function automatic logic is_nucleotide(input logic [7:0] b);
		logic hit;
		begin
			unique case (b)
				8'h41, 8'h43, 8'h47, 8'h54, 8'h55, 8'h52, 8'h59, 8'h4B, 8'h4D,
				8'h53, 8'h57, 8'h42, 8'h44, 8'h48, 8'h56, CH_N, CH_DASH: begin
					hit = 1'b1;
				end
				default: begin
					hit = 1'b0;
				end
			endcase
			return hit;
		end
	endfunction

endpackage

// File: hdl/fasta_stream_tokenizer.sv
// ----------------------------------------------------------------------------
// FASTA stream tokenizer
// Streaming FASTA tokenizer with one byte in and at most one token out.
// ----------------------------------------------------------------------------
// The block takes one FASTA byte, or an end-of-file mark, per transfer and
// produces at most one token per byte. It sustains one byte per clock cycle
// while the output side is not stalled: a byte is registered on arrival, the
// parser's next-state logic handles it from that register, and any token is
// loaded into the output register and presented from there. Bytes that
// produce no token never wait on the output side.

module fasta_stream_tokenizer
	import fst_pkg::*;
#(
	parameter int RECORD_INDEX_BITS = RecordIndexBitsDefault
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    byte_valid,
	output logic                    byte_stall,
	input  logic [7:0]              data_byte,
	input  logic                    end_of_file,
	output logic                    token_valid,
	input  logic                    token_stall,
	output logic [2:0]              token_kind,
	output logic [7:0]              token_char,
	output logic [IndexOutBits-1:0] record_index,
	output logic                    error_code
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       eof_s1;
	logic       advance;
	logic       out_free;
	logic       take;
	token_t     token;

	assign advance    = valid_s1 && (out_free || !token.valid);
	assign byte_stall = valid_s1 && !advance;
	assign take       = byte_valid && !byte_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			byte_s1 <= data_byte;
			eof_s1  <= end_of_file;
		end
	end

	fst_parser #(
		.RECORD_INDEX_BITS(RECORD_INDEX_BITS)
	) u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (advance),
		.data_byte  (byte_s1),
		.end_of_file(eof_s1),
		.token      (token)
	);

	fst_out_reg u_out (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (advance && token.valid),
		.token       (token),
		.free        (out_free),
		.token_valid (token_valid),
		.token_stall (token_stall),
		.token_kind  (token_kind),
		.token_char  (token_char),
		.record_index(record_index),
		.error_code  (error_code)
	);

endmodule

// File: hdl/fst_parser.sv
// ----------------------------------------------------------------------------
// FASTA stream tokenizer parser
// Parse state and the per-byte next-state and token logic.
// ----------------------------------------------------------------------------
`include "fasta_stream_tokenizer_macros.svh"

module fst_parser
	import fst_pkg::*;
#(
	parameter int RECORD_INDEX_BITS = RecordIndexBitsDefault
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         step,
	input  logic [7:0]   data_byte,
	input  logic         end_of_file,
	output token_t       token
);

	localparam logic [2:0] PH_IDLE = 3'd0;
	localparam logic [2:0] PH_NAME = 3'd1;
	localparam logic [2:0] PH_SKIP = 3'd2;
	localparam logic [2:0] PH_BODY = 3'd3;
	localparam logic [2:0] PH_MOD1 = 3'd4;
	localparam logic [2:0] PH_MOD2 = 3'd5;
	localparam logic [2:0] PH_HALT = 3'd6;

	logic [2:0]                   phase_q, phase_d;
	logic                         mod_ok_q, mod_ok_d;
	logic [RECORD_INDEX_BITS-1:0] count_q, count_d;
	logic                         seen_q, seen_d;
	logic [RECORD_INDEX_BITS+IndexOutBits-1:0] count_ext;

	assign count_ext = {{IndexOutBits{1'b0}}, count_q};

	always_comb begin
		token          = '0;
		token.index    = count_ext[IndexOutBits-1:0];
		phase_d        = phase_q;
		mod_ok_d       = mod_ok_q;
		count_d        = count_q;
		seen_d         = seen_q;
		if (end_of_file) begin
			unique case (phase_q)
				PH_NAME, PH_SKIP, PH_BODY: begin
					token.valid = 1'b1;
					token.kind  = KIND_REC_END;
				end
				PH_MOD1, PH_MOD2: begin
					token.valid = 1'b1;
					token.kind  = KIND_ERROR;
					token.err   = ERR_BAD_MOD;
				end
				default: begin
				end
			endcase
			phase_d  = PH_IDLE;
			mod_ok_d = 1'b0;
			count_d  = '0;
			seen_d   = 1'b0;
		end else begin
			unique case (phase_q)
				PH_IDLE: begin
					if (data_byte == CH_GT) begin
						if (seen_q) begin
							count_d = count_q + RECORD_INDEX_BITS'(1);
						end
						seen_d  = 1'b1;
						phase_d = PH_NAME;
					end
				end
				PH_NAME: begin
					token.valid = 1'b1;
					if (data_byte == CH_SPACE || data_byte == CH_BAR) begin
						token.kind = KIND_NAME_END;
						phase_d    = PH_SKIP;
					end else if (data_byte == CH_NEWLINE) begin
						token.kind = KIND_NAME_END;
						phase_d    = PH_BODY;
					end else begin
						token.kind     = KIND_NAME_CHAR;
						token.char_val = data_byte;
					end
				end
				PH_SKIP: begin
					if (data_byte == CH_NEWLINE) begin
						phase_d = PH_BODY;
					end
				end
				PH_BODY: begin
					priority if (data_byte == CH_GT) begin
						token.valid = 1'b1;
						token.kind  = KIND_REC_END;
						if (seen_q) begin
							count_d = count_q + RECORD_INDEX_BITS'(1);
						end
						seen_d  = 1'b1;
						phase_d = PH_NAME;
					end else if (data_byte == CH_LPAREN) begin
						phase_d = PH_MOD1;
					end else if (data_byte == CH_NEWLINE) begin
						phase_d = PH_BODY;
					end else if (is_nucleotide(data_byte)) begin
						token.valid    = 1'b1;
						token.kind     = KIND_SEQ_CHAR;
						token.char_val = data_byte;
					end else begin
						token.valid = 1'b1;
						token.kind  = KIND_ERROR;
						token.err   = ERR_BAD_CHAR;
						phase_d     = PH_HALT;
					end
				end
				PH_MOD1: begin
					mod_ok_d = (data_byte == CH_I);
					phase_d  = PH_MOD2;
				end
				PH_MOD2: begin
					token.valid = 1'b1;
					if (mod_ok_q && data_byte == CH_RPAREN) begin
						token.kind     = KIND_SEQ_CHAR;
						token.char_val = CH_I;
						phase_d        = PH_BODY;
					end else begin
						token.kind = KIND_ERROR;
						token.err  = ERR_BAD_MOD;
						phase_d    = PH_HALT;
					end
					mod_ok_d = 1'b0;
				end
				default: begin
					phase_d = PH_HALT;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			mod_ok_q <= 1'b0;
			count_q  <= '0;
			seen_q   <= 1'b0;
		end else if (step) begin
			phase_q  <= phase_d;
			mod_ok_q <= mod_ok_d;
			count_q  <= count_d;
			seen_q   <= seen_d;
		end
	end

	`FST_ASSERT_NEXT(a_eof_clears, step && end_of_file,
		phase_q == PH_IDLE && count_q == '0 && !seen_q)
	`FST_ASSERT_NEXT(a_error_halts,
		step && !end_of_file && token.valid && token.kind == KIND_ERROR,
		phase_q == PH_HALT)
	`FST_ASSERT_NEXT(a_count_holds, !step, $stable(count_q) && $stable(phase_q))
	`FST_ASSERT_SAME(a_halt_silent, phase_q == PH_HALT && !end_of_file, !token.valid)

endmodule

// File: hdl/fst_out_reg.sv
// ----------------------------------------------------------------------------
// FASTA stream tokenizer output register
// Holds one finished token until the downstream side takes it.
// ----------------------------------------------------------------------------
`include "fasta_stream_tokenizer_macros.svh"

module fst_out_reg
	import fst_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    load,
	input  token_t                  token,
	output logic                    free,
	output logic                    token_valid,
	input  logic                    token_stall,
	output logic [2:0]              token_kind,
	output logic [7:0]              token_char,
	output logic [IndexOutBits-1:0] record_index,
	output logic                    error_code
);

	logic   valid_q;
	token_t data_q;

	assign free = !valid_q || !token_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!token_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= token;
		end
	end

	assign token_valid  = valid_q;
	assign token_kind   = data_q.kind;
	assign token_char   = data_q.char_val;
	assign record_index = data_q.index;
	assign error_code   = data_q.err;

	`FST_ASSERT_SAME(a_load_only_free, load, free)
	`FST_ASSERT_NEXT(a_stalled_kept, valid_q && token_stall, valid_q)
	`FST_ASSERT_NEXT(a_load_shows, load, valid_q && data_q == $past(token))

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FASTA stream tokenizer testbench
// Feeds directed and random FASTA byte streams through the tokenizer with
// random bursts on the input side and random stalls on the token side. An
// independent model of the parser predicts every token, and each token that
// comes out is compared with the oldest prediction.
// ----------------------------------------------------------------------------

typedef enum logic [2:0] {
	PARSE_IDLE,
	PARSE_NAME,
	PARSE_SKIP,
	PARSE_BODY,
	PARSE_MOD_OPEN,
	PARSE_MOD_CLOSE,
	PARSE_HALT
} parse_phase_t;

typedef struct {
	logic [2:0]                      kind;
	logic [7:0]                      ch;
	logic [fst_pkg::IndexOutBits-1:0] idx;
	logic                            err;
} fasta_token_t;

class token_scoreboard;
	parse_phase_t phase;
	bit mod_ok;
	logic [fst_pkg::IndexOutBits-1:0] rec_num;
	bit rec_open;
	fasta_token_t pending_tokens[$];
	int mismatches;
	int byte_count;

	function new();
		restart();
		mismatches = 0;
		byte_count = 0;
	endfunction

	function void restart();
		phase = PARSE_IDLE;
		mod_ok = 1'b0;
		rec_num = '0;
		rec_open = 1'b0;
	endfunction

	function void queue_token(logic [2:0] kind, logic [7:0] ch, logic err);
		fasta_token_t t;
		t.kind = kind;
		t.ch = ch;
		t.idx = rec_num;
		t.err = err;
		pending_tokens.insert(pending_tokens.size(), t);
	endfunction

	function void open_record();
		if (rec_open) begin
			rec_num = rec_num + 1'b1;
		end
		rec_open = 1'b1;
		phase = PARSE_NAME;
	endfunction

	function bit is_base(logic [7:0] b);
		case (b)
			"A", "C", "G", "T", "U", "R", "Y", "K", "M",
			"S", "W", "B", "D", "H", "V", "N", "-": begin
				return 1'b1;
			end
			default: begin
				return 1'b0;
			end
		endcase
	endfunction

	function void note_byte(logic [7:0] b, logic eof);
		byte_count++;
		if (eof) begin
			case (phase)
				PARSE_NAME, PARSE_SKIP, PARSE_BODY: begin
					queue_token(fst_pkg::KIND_REC_END, 8'h00, fst_pkg::ERR_BAD_CHAR);
				end
				PARSE_MOD_OPEN, PARSE_MOD_CLOSE: begin
					queue_token(fst_pkg::KIND_ERROR, 8'h00, fst_pkg::ERR_BAD_MOD);
				end
				default: begin
				end
			endcase
			restart();
			return;
		end
		case (phase)
			PARSE_IDLE: begin
				if (b == fst_pkg::CH_GT) begin
					open_record();
				end
			end
			PARSE_NAME: begin
				if (b == fst_pkg::CH_SPACE || b == fst_pkg::CH_BAR) begin
					phase = PARSE_SKIP;
					queue_token(fst_pkg::KIND_NAME_END, 8'h00, fst_pkg::ERR_BAD_CHAR);
				end else if (b == fst_pkg::CH_NEWLINE) begin
					phase = PARSE_BODY;
					queue_token(fst_pkg::KIND_NAME_END, 8'h00, fst_pkg::ERR_BAD_CHAR);
				end else begin
					queue_token(fst_pkg::KIND_NAME_CHAR, b, fst_pkg::ERR_BAD_CHAR);
				end
			end
			PARSE_SKIP: begin
				if (b == fst_pkg::CH_NEWLINE) begin
					phase = PARSE_BODY;
				end
			end
			PARSE_BODY: begin
				if (b == fst_pkg::CH_GT) begin
					queue_token(fst_pkg::KIND_REC_END, 8'h00, fst_pkg::ERR_BAD_CHAR);
					open_record();
				end else if (b == fst_pkg::CH_LPAREN) begin
					phase = PARSE_MOD_OPEN;
				end else if (b == fst_pkg::CH_NEWLINE) begin
				end else if (is_base(b)) begin
					queue_token(fst_pkg::KIND_SEQ_CHAR, b, fst_pkg::ERR_BAD_CHAR);
				end else begin
					phase = PARSE_HALT;
					queue_token(fst_pkg::KIND_ERROR, 8'h00, fst_pkg::ERR_BAD_CHAR);
				end
			end
			PARSE_MOD_OPEN: begin
				mod_ok = (b == fst_pkg::CH_I);
				phase = PARSE_MOD_CLOSE;
			end
			PARSE_MOD_CLOSE: begin
				if (mod_ok && b == fst_pkg::CH_RPAREN) begin
					phase = PARSE_BODY;
					queue_token(fst_pkg::KIND_SEQ_CHAR, fst_pkg::CH_I, fst_pkg::ERR_BAD_CHAR);
				end else begin
					phase = PARSE_HALT;
					queue_token(fst_pkg::KIND_ERROR, 8'h00, fst_pkg::ERR_BAD_MOD);
				end
				mod_ok = 1'b0;
			end
			default: begin
				phase = PARSE_HALT;
			end
		endcase
	endfunction

	function void check_token(logic [2:0] kind, logic [7:0] ch,
			logic [fst_pkg::IndexOutBits-1:0] idx, logic err);
		fasta_token_t t;
		if (pending_tokens.size() == 0) begin
			mismatches++;
			if (mismatches <= 10) begin
				$display("Unexpected token: kind %0d char %02h index %0d code %0d",
					kind, ch, idx, err);
			end
			return;
		end
		t = pending_tokens.pop_front();
		if (kind !== t.kind || ch !== t.ch || idx !== t.idx || err !== t.err) begin
			mismatches++;
			if (mismatches <= 10) begin
				$display("Token mismatch: expected %0d/%02h/%0d/%0d, got %0d/%02h/%0d/%0d",
					t.kind, t.ch, t.idx, t.err, kind, ch, idx, err);
			end
		end
	endfunction
endclass

module testbench;
	import fst_pkg::*;

	localparam int QuietLimit = 2000;
	localparam int ByteTarget = 1400;

	logic clk;
	logic arst_n;
	logic byte_valid;
	logic byte_stall;
	logic [7:0] data_byte;
	logic end_of_file;
	logic token_valid;
	logic token_stall;
	logic [2:0] token_kind;
	logic [7:0] token_char;
	logic [IndexOutBits-1:0] record_index;
	logic error_code;

	token_scoreboard sb;
	int quiet_cycles = 0;
	int burst_left = 0;
	int stall_mode = 0;
	int stall_left = 0;
	int stall_tick = 0;
	string base_letters = "ACGTURYKMSWBDHVN-";

	fasta_stream_tokenizer DUT (
		.clk(clk),
		.arst_n(arst_n),
		.byte_valid(byte_valid),
		.byte_stall(byte_stall),
		.data_byte(data_byte),
		.end_of_file(end_of_file),
		.token_valid(token_valid),
		.token_stall(token_stall),
		.token_kind(token_kind),
		.token_char(token_char),
		.record_index(record_index),
		.error_code(error_code)
	);

	always #5 clk = ~clk;

	// The token side switches between stall patterns, picked at random.
	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_left = $urandom_range(20, 200);
		end
		stall_left--;
		stall_tick++;
		case (stall_mode)
			0: begin
				token_stall <= 1'b0;
			end
			1: begin
				token_stall <= ($urandom_range(0, 3) == 0);
			end
			2: begin
				token_stall <= ($urandom_range(0, 3) != 0);
			end
			default: begin
				token_stall <= ((stall_tick % 5) < 2);
			end
		endcase
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (byte_valid && !byte_stall) begin
				sb.note_byte(data_byte, end_of_file);
			end
			if (token_valid && !token_stall) begin
				sb.check_token(token_kind, token_char, record_index, error_code);
			end
			if ((byte_valid && !byte_stall) || (token_valid && !token_stall)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
			if (quiet_cycles >= QuietLimit) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	// Called at a falling edge; returns at the falling edge after the transfer.
	task automatic send_byte(input logic [7:0] b, input logic eof);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 1) ? 0 : $urandom_range(1, 5);
			repeat (gap) begin
				byte_valid <= 1'b0;
				@(negedge clk);
			end
			burst_left = $urandom_range(1, 30);
		end
		burst_left--;
		byte_valid <= 1'b1;
		data_byte <= b;
		end_of_file <= eof;
		do begin
			@(posedge clk);
		end while (byte_stall);
		@(negedge clk);
	endtask

	task automatic send_text(input string s);
		for (int k = 0; k < s.len(); k++) begin
			send_byte(s[k], 1'b0);
		end
	endtask

	task automatic send_body_symbol();
		int r;
		r = $urandom_range(0, 199);
		if (r < 160) begin
			send_byte(base_letters[$urandom_range(0, 16)], 1'b0);
		end else if (r < 176) begin
			send_text("(i)");
		end else if (r < 184) begin
			send_byte(CH_NEWLINE, 1'b0);
		end else if (r < 189) begin
			send_byte(CH_LPAREN, 1'b0);
			send_byte($urandom_range(0, 1) ? CH_I : 8'($urandom), 1'b0);
			send_byte($urandom_range(0, 1) ? CH_RPAREN : 8'($urandom), 1'b0);
		end else if (r < 193) begin
			send_byte(8'($urandom), 1'b0);
		end else if (r < 195) begin
			send_byte(CH_LPAREN, 1'b0);
			send_byte(8'($urandom), 1'b1);
		end else if (r < 197) begin
			send_text("(i");
			send_byte(8'($urandom), 1'b1);
		end else begin
			send_byte(8'($urandom), 1'b1);
		end
	endtask

	task automatic send_random_file();
		if ($urandom_range(0, 7) == 0) begin
			repeat ($urandom_range(5, 20)) begin
				send_byte(8'($urandom), ($urandom_range(0, 9) == 0));
			end
		end
		repeat ($urandom_range(0, 3)) begin
			send_byte(8'($urandom), 1'b0);
		end
		repeat ($urandom_range(1, 4)) begin
			send_byte(CH_GT, 1'b0);
			repeat ($urandom_range(0, 6)) begin
				send_byte($urandom_range(0, 7) == 0 ? 8'($urandom)
					: 8'($urandom_range(8'h21, 8'h7E)), 1'b0);
			end
			if ($urandom_range(0, 19) == 0) begin
				send_byte(8'($urandom), 1'b1);
			end
			case ($urandom_range(0, 2))
				0: begin
					send_byte(CH_NEWLINE, 1'b0);
				end
				default: begin
					send_byte($urandom_range(0, 1) ? CH_SPACE : CH_BAR, 1'b0);
					repeat ($urandom_range(0, 5)) begin
						send_byte(8'($urandom_range(8'h20, 8'h7E)), 1'b0);
					end
					if ($urandom_range(0, 19) == 0) begin
						send_byte(8'($urandom), 1'b1);
					end
					send_byte(CH_NEWLINE, 1'b0);
				end
			endcase
			repeat ($urandom_range(0, 3)) begin
				repeat ($urandom_range(0, 10)) begin
					send_body_symbol();
				end
				send_byte(CH_NEWLINE, 1'b0);
			end
		end
		send_byte(8'($urandom), 1'b1);
	endtask

	initial begin
		sb = new();
		clk = 1'b0;
		arst_n = 1'b0;
		byte_valid = 1'b0;
		data_byte = 8'h00;
		end_of_file = 1'b0;
		token_stall = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Junk before the first header, end of file while idle, extreme name
		// bytes, '>' inside a name and a skipped header, a name ended by a
		// newline, a good and a bad modifier, and bytes ignored while halted.
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h00, 1'b1);
		send_byte(CH_GT, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(CH_GT, 1'b0);
		send_byte(CH_BAR, 1'b0);
		send_byte(CH_GT, 1'b0);
		send_text("\nA\n(i)-N>\n(x)>");
		send_byte(8'hFF, 1'b1);
		send_text(">Q");
		send_byte(8'h00, 1'b1);

		while (sb.byte_count < ByteTarget) begin
			send_random_file();
		end
		byte_valid <= 1'b0;

		while (sb.pending_tokens.size() != 0) begin
			@(posedge clk);
		end
		repeat (20) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending_tokens.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
